[design/hll_pkg.sv]
// Package for the distinct-count sketch: sizes, constants, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hll_pkg;

   localparam int unsigned PRECISION = 10;
   localparam int unsigned NREG      = 1 << PRECISION;
   localparam int unsigned IDX_W     = PRECISION;
   localparam int unsigned RANK_W    = 6;
   localparam int unsigned HASH_W    = 64;
   localparam int unsigned EST_W     = 63;
   localparam int unsigned ZCNT_W    = PRECISION + 1;
   localparam int unsigned SUM_W     = 64 + PRECISION + 1;
   localparam int unsigned CNT_W     = (PRECISION > 7) ? PRECISION : 7;
   localparam int unsigned DIV_STEPS = 128;
   localparam int unsigned LOG_STEPS = 32;

   localparam logic [63:0] LN2_Q32 = 64'd2977044471;
   localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

   // Bias constant, Q0.32
   localparam logic [63:0] ALPHA_Q32 =
      (PRECISION == 4) ? (64'd673 << 32) / 64'd1000 :
      (PRECISION == 5) ? (64'd697 << 32) / 64'd1000 :
      (PRECISION == 6) ? (64'd709 << 32) / 64'd1000 :
      ((64'd7213 * 64'(NREG)) << 32) / (64'd10 * (64'd1000 * 64'(NREG) + 64'd1079));
   localparam logic [63:0] ALPHA_MM = 64'(ALPHA_Q32 * 64'(NREG) * 64'(NREG));

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_MERGE  = 2'd1,
      OP_FINAL  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_SUM, ST_SUM_DRAIN,
      ST_SELECT, ST_LOG, ST_LN, ST_DIV, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_LATCH, DP_UPD_RD, DP_UPD_WR, DP_CLR, DP_SUM_RD,
      DP_LOG_INIT, DP_LOG_STEP, DP_LN, DP_DIV_INIT, DP_DIV_STEP, DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [CNT_W-1:0] cnt;
   } dp_cmd_type;

   typedef struct packed {
      logic zeros_nz;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

[design/hll_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hll_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] addr,
   input  wire [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/hll_ctrl.sv]
// Controller state machine: sequences clear sweeps, register updates and finalize.
// Depends on hll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hll_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   input  wire [1:0]               req_op,
   output logic                    req_tready,
   input  hll_pkg::dp_status_type  status,
   output hll_pkg::dp_cmd_type     cmd
);

   hll_pkg::state_type          state_ff, state_in;
   logic [hll_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hll_pkg::ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and datapath command
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd.op     = hll_pkg::DP_NONE;
      cmd.cnt    = cnt_ff;
      unique case (state_ff)
         hll_pkg::ST_CLEAR: begin
            cmd.op = hll_pkg::DP_CLR;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hll_pkg::CNT_W'(hll_pkg::NREG - 1)) begin
               cnt_in   = '0;
               state_in = hll_pkg::ST_IDLE;
            end
         end
         hll_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid) begin
               cmd.op = hll_pkg::DP_LATCH;
               case (hll_pkg::op_type'(req_op))
                  hll_pkg::OP_UPDATE,
                  hll_pkg::OP_MERGE: state_in = hll_pkg::ST_UPD_RD;
                  hll_pkg::OP_FINAL: state_in = hll_pkg::ST_SUM;
                  default:           state_in = hll_pkg::ST_CLEAR;
               endcase
            end
         end
         hll_pkg::ST_UPD_RD: begin
            cmd.op   = hll_pkg::DP_UPD_RD;
            state_in = hll_pkg::ST_UPD_WR;
         end
         hll_pkg::ST_UPD_WR: begin
            cmd.op   = hll_pkg::DP_UPD_WR;
            state_in = hll_pkg::ST_IDLE;
         end
         hll_pkg::ST_SUM: begin
            cmd.op = hll_pkg::DP_SUM_RD;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hll_pkg::CNT_W'(hll_pkg::NREG - 1)) begin
               cnt_in   = '0;
               state_in = hll_pkg::ST_SUM_DRAIN;
            end
         end
         hll_pkg::ST_SUM_DRAIN: begin
            state_in = hll_pkg::ST_SELECT;
         end
         hll_pkg::ST_SELECT: begin
            cnt_in = '0;
            if (status.zeros_nz) begin
               cmd.op   = hll_pkg::DP_LOG_INIT;
               state_in = hll_pkg::ST_LOG;
            end else begin
               cmd.op   = hll_pkg::DP_DIV_INIT;
               state_in = hll_pkg::ST_DIV;
            end
         end
         hll_pkg::ST_LOG: begin
            cmd.op = hll_pkg::DP_LOG_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hll_pkg::CNT_W'(hll_pkg::LOG_STEPS - 1)) begin
               state_in = hll_pkg::ST_LN;
            end
         end
         hll_pkg::ST_LN: begin
            cmd.op   = hll_pkg::DP_LN;
            state_in = hll_pkg::ST_OUT;
         end
         hll_pkg::ST_DIV: begin
            cmd.op = hll_pkg::DP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hll_pkg::CNT_W'(hll_pkg::DIV_STEPS - 1)) begin
               state_in = hll_pkg::ST_OUT;
            end
         end
         hll_pkg::ST_OUT: begin
            if (!status.out_busy) begin
               cmd.op   = hll_pkg::DP_PUBLISH;
               state_in = hll_pkg::ST_IDLE;
            end
         end
         default: state_in = hll_pkg::ST_IDLE;
      endcase
   end

   // A result is only published into a free output register
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == hll_pkg::DP_PUBLISH |-> !status.out_busy)
      else $error("result published over a pending one");

   // No input is taken while the clear sweep runs
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == hll_pkg::ST_CLEAR |-> !req_tready)
      else $error("input accepted during clear");

   // Finalize reaches the output only after a full sweep
   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == hll_pkg::ST_SUM_DRAIN |->
         $past(cnt_ff) == hll_pkg::CNT_W'(hll_pkg::NREG - 1))
      else $error("sweep ended early");

endmodule

`default_nettype wire

[design/hll_dp.sv]
// Datapath: rank store, rank compute, harmonic sum, log2/ln unit, divider and
// the output register. Depends on hll_pkg and hll_ram.
`timescale 1ns / 1ps
`default_nettype none

module hll_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  hll_pkg::dp_cmd_type          cmd,
   output hll_pkg::dp_status_type       status,
   input  wire [1:0]                    req_op,
   input  wire [hll_pkg::HASH_W-1:0]    req_hash,
   input  wire [9:0]                    req_index,
   input  wire [hll_pkg::RANK_W-1:0]    req_value,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [hll_pkg::EST_W-1:0]    rsp_est,
   output logic                         rsp_linear
);

   localparam int unsigned P = hll_pkg::PRECISION;

   // Latched item
   logic [hll_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [hll_pkg::RANK_W-1:0] rank_ff, rank_in;
   logic                       skip_ff, skip_in;

   // RAM port
   logic                       ram_we;
   logic [hll_pkg::IDX_W-1:0]  ram_addr;
   logic [hll_pkg::RANK_W-1:0] ram_wdata, ram_rdata;

   // Sum of 2^-r (64 fraction bits) and zero count
   logic                        acc_en_ff;
   logic [hll_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [hll_pkg::ZCNT_W-1:0]  zeros_ff, zeros_in;
   logic [64:0]                 term;

   // Log unit
   logic [4:0]   e_ff, e_in;
   logic [31:0]  y_ff, y_in, frac_ff, frac_in;
   logic [63:0]  sq;
   logic [32:0]  sq_t;
   logic [36:0]  dval;
   logic [63:0]  ln_val;

   // Divider
   logic [127:0]              num_ff, num_in;
   logic [hll_pkg::SUM_W:0]   rem_ff, rem_in, rem_sh;
   logic [hll_pkg::EST_W-1:0] q_ff, q_in;
   logic                      over_ff, over_in, div_ge;

   // Pending result and output register
   logic [hll_pkg::EST_W-1:0] est_ff, est_in, out_est_ff, out_est_in;
   logic                      lin_ff, lin_in, out_lin_ff, out_lin_in;
   logic                      out_vld_ff, out_vld_in;

   hll_ram #(.WIDTH(hll_pkg::RANK_W), .DEPTH(hll_pkg::NREG)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Item latch: index, rank and skip flag
   always_comb begin
      idx_in  = idx_ff;
      rank_in = rank_ff;
      skip_in = skip_ff;
      if (cmd.op == hll_pkg::DP_LATCH) begin
         if (hll_pkg::op_type'(req_op) == hll_pkg::OP_UPDATE) begin
            idx_in  = req_hash[hll_pkg::IDX_W-1:0];
            skip_in = (req_hash == '0);
            rank_in = hll_pkg::RANK_W'(65 - P);
            for (int i = 63; i >= int'(P); i--) begin
               if (req_hash[i]) begin
                  rank_in = hll_pkg::RANK_W'(i - int'(P) + 1);
               end
            end
         end else begin
            idx_in  = hll_pkg::IDX_W'(req_index);
            skip_in = 1'b0;
            rank_in = req_value;
         end
      end
   end

   // RAM access
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = idx_ff;
      ram_wdata = rank_ff;
      case (cmd.op)
         hll_pkg::DP_CLR: begin
            ram_we    = 1'b1;
            ram_addr  = cmd.cnt[hll_pkg::IDX_W-1:0];
            ram_wdata = '0;
         end
         hll_pkg::DP_SUM_RD: ram_addr = cmd.cnt[hll_pkg::IDX_W-1:0];
         hll_pkg::DP_UPD_WR: ram_we = !skip_ff && (rank_ff > ram_rdata);
         default: ;
      endcase
   end

   // Harmonic sum accumulation, one register per cycle
   always_comb begin
      term     = (ram_rdata == '0) ? (65'd1 << 64) : (65'd1 << (7'd64 - 7'(ram_rdata)));
      sum_in   = sum_ff;
      zeros_in = zeros_ff;
      if (cmd.op == hll_pkg::DP_LATCH) begin
         sum_in   = '0;
         zeros_in = '0;
      end else if (acc_en_ff) begin
         sum_in = sum_ff + hll_pkg::SUM_W'(term);
         if (ram_rdata == '0) begin
            zeros_in = zeros_ff + 1'b1;
         end
      end
   end

   // log2 by repeated squaring, then ln and linear-counting estimate
   always_comb begin
      e_in    = e_ff;
      y_in    = y_ff;
      frac_in = frac_ff;
      sq      = 64'(y_ff) * 64'(y_ff);
      sq_t    = sq[63:31];
      if (cmd.op == hll_pkg::DP_LOG_INIT) begin
         e_in = '0;
         for (int i = 0; i < int'(hll_pkg::ZCNT_W); i++) begin
            if (zeros_ff[i]) begin
               e_in = 5'(i);
            end
         end
         y_in    = 32'(zeros_ff) << (5'd31 - e_in);
         frac_in = '0;
      end else if (cmd.op == hll_pkg::DP_LOG_STEP) begin
         frac_in = {frac_ff[30:0], sq_t[32]};
         y_in    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
      end
      dval   = (37'(P) << 32) - {e_ff, frac_ff};
      ln_val = 64'(dval[36:32]) * hll_pkg::LN2_Q32
             + ((64'(dval[31:0]) * hll_pkg::LN2_Q32) >> 32);
   end

   // Restoring divider, one quotient bit per cycle; numerator is alpha*m*m*2^32
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      over_in = over_ff;
      rem_sh  = {rem_ff[hll_pkg::SUM_W-1:0], num_ff[127]};
      div_ge  = (rem_sh >= {1'b0, sum_ff});
      if (cmd.op == hll_pkg::DP_DIV_INIT) begin
         num_in  = {32'd0, hll_pkg::ALPHA_MM, 32'd0};
         rem_in  = '0;
         q_in    = '0;
         over_in = 1'b0;
      end else if (cmd.op == hll_pkg::DP_DIV_STEP) begin
         num_in = {num_ff[126:0], 1'b0};
         rem_in = div_ge ? (rem_sh - {1'b0, sum_ff}) : rem_sh;
         q_in   = {q_ff[hll_pkg::EST_W-2:0], div_ge};
         if (div_ge && cmd.cnt <= hll_pkg::CNT_W'(64)) begin
            over_in = 1'b1;
         end
      end
   end

   // Pending result and output register
   always_comb begin
      est_in     = est_ff;
      lin_in     = lin_ff;
      out_est_in = out_est_ff;
      out_lin_in = out_lin_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      case (cmd.op)
         hll_pkg::DP_LOG_INIT: lin_in = 1'b1;
         hll_pkg::DP_DIV_INIT: lin_in = 1'b0;
         hll_pkg::DP_LN:       est_in = hll_pkg::EST_W'(ln_val >> (32 - P));
         hll_pkg::DP_PUBLISH: begin
            out_vld_in = 1'b1;
            out_lin_in = lin_ff;
            out_est_in = lin_ff ? est_ff : (over_ff ? hll_pkg::EST_MAX : q_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         acc_en_ff  <= (cmd.op == hll_pkg::DP_SUM_RD);
         out_vld_ff <= out_vld_in;
      end
      idx_ff     <= idx_in;
      rank_ff    <= rank_in;
      skip_ff    <= skip_in;
      sum_ff     <= sum_in;
      zeros_ff   <= zeros_in;
      e_ff       <= e_in;
      y_ff       <= y_in;
      frac_ff    <= frac_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      over_ff    <= over_in;
      est_ff     <= est_in;
      lin_ff     <= lin_in;
      out_est_ff <= out_est_in;
      out_lin_ff <= out_lin_in;
   end

   assign status.zeros_nz = (zeros_ff != '0);
   assign status.out_busy = out_vld_ff && !rsp_tready;
   assign rsp_tvalid      = out_vld_ff;
   assign rsp_est         = out_est_ff;
   assign rsp_linear      = out_lin_ff;

endmodule

`default_nettype wire

[design/hyperloglog_distinct_count_sketch_core.sv]
// HyperLogLog distinct-count sketch, top level: stream ports, controller and datapath.
// Depends on hll_pkg, hll_ctrl, hll_dp (and hll_ram through hll_dp).
//
// Keeps 2^PRECISION six-bit rank registers in a single-port RAM. After reset,
// and after every clear transaction, the block sweeps all NREG registers
// (1024 at PRECISION 10) to zero and holds req_tready low meanwhile.
// Update and merge each run accept, RAM read and RAM write in turn, set by the
// read-modify-write on the one RAM port. Finalize reads every register once,
// then runs either the 32-step log2 unit plus one ln step, or the 128-step
// restoring divider, and publishes one result.
// Only finalize produces a result transaction.
`timescale 1ns / 1ps
`default_nettype none

module hyperloglog_distinct_count_sketch_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [79:0]  req_tdata,   // hash_value[63:0], reg_index[73:64], reg_value[79:74]
   input  wire [1:0]   req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // estimate[62:0], zero pad[63]
   output logic [0:0]  rsp_tuser    // used_linear[0]
);

   hll_pkg::dp_cmd_type          cmd;
   hll_pkg::dp_status_type       status;
   logic [hll_pkg::EST_W-1:0]    est;
   logic                         linear;

   hll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hll_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_tuser),
      .req_hash   (req_tdata[63:0]),
      .req_index  (req_tdata[73:64]),
      .req_value  (req_tdata[79:74]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_est    (est),
      .rsp_linear (linear)
   );

   assign rsp_tdata = {1'b0, est};
   assign rsp_tuser = linear;

endmodule

`default_nettype wire

[tb/hyperloglog_distinct_count_sketch_core_tb.sv]
// Testbench for the distinct-count sketch core: directed table, then random streams,
// all results checked against a behavioral sketch model kept in this file.
// Depends on hll_pkg and hyperloglog_distinct_count_sketch_core.
`timescale 1ns / 1ps

module hyperloglog_distinct_count_sketch_core_tb;

   localparam int unsigned PRECISION = hll_pkg::PRECISION;
   localparam int unsigned NREG      = hll_pkg::NREG;
   localparam int unsigned IDX_W     = hll_pkg::IDX_W;
   localparam int unsigned RANK_W    = hll_pkg::RANK_W;
   localparam int unsigned EST_W     = hll_pkg::EST_W;
   localparam logic [63:0] LN2_Q32   = hll_pkg::LN2_Q32;
   localparam logic [hll_pkg::EST_W-1:0] EST_MAX = hll_pkg::EST_MAX;

   localparam int unsigned CYCLE_LIMIT  = 15000000;
   localparam int unsigned RANDOM_ITEMS = 400;
   localparam int unsigned QUIET_TAIL   = 100;
   localparam int unsigned HOLD_CYCLES  = 3000;
   localparam int unsigned DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [EST_W-1:0] estimate;
      logic             used_linear;
   } estimate_type;

   typedef struct {
      hll_pkg::op_type op;
      logic [63:0]     row_hash;
      logic [9:0]      reg_index;
      logic [5:0]      reg_value;
      int unsigned     repeat_cnt;   // merge rows walk reg_index upward
      bit              has_literal;
      estimate_type    literal;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;  // hash_value[63:0], reg_index[73:64], reg_value[79:74]
   logic [1:0]  req_tuser = '0;  // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [63:0] rsp_tdata;       // estimate[62:0], zero pad[63]
   logic [0:0]  rsp_tuser;       // used_linear[0]

   logic [RANK_W-1:0] sketch_ranks [0:NREG-1];
   estimate_type      pending_estimates [$];
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;
   bit                idle_on = 1'b0;
   bit                hold_request = 1'b0;

   hyperloglog_distinct_count_sketch_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // rank of an update hash: one plus trailing zeros of the part above the index
   function automatic int unsigned hash_rank(input logic [63:0] h);
      logic [63:0] upper;
      int unsigned r;
      upper = h >> PRECISION;
      if (upper == 0) return 64 - PRECISION + 1;
      r = 1;
      while (upper[0] == 1'b0) begin
         upper = upper >> 1;
         r++;
      end
      return r;
   endfunction

   // log2(z) in Q.32 by repeated squaring
   function automatic logic [63:0] log2_fixed(input int unsigned z);
      int unsigned e;
      logic [127:0] y;
      logic [31:0]  frac;
      e = 0;
      frac = '0;
      while (e < 31 && (z >> (e + 1)) != 0) e++;
      y = 128'(z) << (31 - e);
      for (int i = 0; i < 32; i++) begin
         y = (y * y) >> 31;
         frac = frac << 1;
         if (y >= (128'd1 << 32)) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return {32'(e), frac};
   endfunction

   function automatic estimate_type sketch_estimate();
      estimate_type res;
      int unsigned  zeros;
      logic [127:0] sum, num, quot;
      logic [63:0]  alpha, ln_arg, ln_val, est;
      zeros = 0;
      sum = '0;
      for (int i = 0; i < NREG; i++) begin
         if (sketch_ranks[i] == 0) begin
            zeros++;
            sum += 128'd1 << 64;
         end else begin
            sum += 128'd1 << (64 - sketch_ranks[i]);
         end
      end
      if (zeros != 0) begin
         ln_arg = (64'(PRECISION) << 32) - log2_fixed(zeros);
         ln_val = (ln_arg >> 32) * LN2_Q32 + (((ln_arg & 64'hFFFF_FFFF) * LN2_Q32) >> 32);
         est = (64'(NREG) * ln_val) >> 32;
         res.estimate = est[EST_W-1:0];
         res.used_linear = 1'b1;
      end else begin
         alpha = ((64'd7213 * 64'(NREG)) << 32) / (64'd10 * (64'd1000 * 64'(NREG) + 64'd1079));
         num = 128'(64'(alpha * 64'(NREG) * 64'(NREG))) << 32;
         quot = num / sum;
         res.estimate = (quot >= (128'd1 << 63)) ? EST_MAX : quot[EST_W-1:0];
         res.used_linear = 1'b0;
      end
      return res;
   endfunction

   // apply one accepted transaction to the sketch model
   task automatic apply_sketch_op(input hll_pkg::op_type op, input logic [63:0] h,
                                  input logic [9:0] idx, input logic [5:0] val);
      int unsigned r;
      logic [IDX_W-1:0] slot;
      case (op)
         hll_pkg::OP_UPDATE: begin
            if (h != 0) begin
               slot = h[IDX_W-1:0];
               r = hash_rank(h);
               if (r > sketch_ranks[slot]) sketch_ranks[slot] = RANK_W'(r);
            end
         end
         hll_pkg::OP_MERGE: begin
            slot = IDX_W'(idx);
            if (val > sketch_ranks[slot]) sketch_ranks[slot] = val;
         end
         hll_pkg::OP_FINAL: pending_estimates.push_back(sketch_estimate());
         default: begin
            for (int i = 0; i < NREG; i++) sketch_ranks[i] = '0;
         end
      endcase
   endtask

   // drive one transaction at the falling edge and wait for it to be taken
   task automatic send_item(input hll_pkg::op_type op, input logic [63:0] h,
                            input logic [9:0] idx, input logic [5:0] val);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {val, idx, h};
      req_tuser = op;
      do @(posedge clock); while (!req_tready);
      apply_sketch_op(op, h, idx, val);
   endtask

   // fill every register through merges, ranks bounded by max_rank
   task automatic fill_sketch(input int unsigned max_rank);
      for (int i = 0; i < NREG; i++)
         send_item(hll_pkg::OP_MERGE, {$urandom, $urandom}, 10'(i),
                   6'($urandom_range(1, max_rank)));
   endtask

   function automatic logic [63:0] random_hash();
      logic [63:0] h;
      h = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: h = h & 64'h3FF;                            // upper part all zero
         1: h = h & ~((64'd1 << $urandom_range(10, 50)) - 1) | (h & 64'h3FF);
         2: h = h | (64'd1 << 63);
         default: ;
      endcase
      return h;
   endfunction

   // result side: random stalls, one long hold-off on request
   initial begin
      int unsigned stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_tready = 1'b0;
            stall = $urandom_range(0, 15);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      estimate_type exp_res;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_estimates.size() == 0) begin
            report_mismatch($sformatf("unexpected result est=%0d lin=%0d",
                                      rsp_tdata[EST_W-1:0], rsp_tuser[0]));
         end else begin
            exp_res = pending_estimates.pop_front();
            if (rsp_tdata[EST_W-1:0] !== exp_res.estimate)
               report_mismatch($sformatf("estimate got %0d want %0d",
                                         rsp_tdata[EST_W-1:0], exp_res.estimate));
            if (rsp_tuser[0] !== exp_res.used_linear)
               report_mismatch($sformatf("used_linear got %0d want %0d",
                                         rsp_tuser[0], exp_res.used_linear));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hyperloglog_distinct_count_sketch_core_tb: errors");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      estimate_type got;
      int unsigned  roll;

      for (int i = 0; i < NREG; i++) sketch_ranks[i] = '0;

      // directed rows; literal results where they are obvious
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b1, '{63'd0, 1'b1}});
      rows.push_back('{hll_pkg::OP_UPDATE, 64'd0, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b1, '{63'd0, 1'b1}});
      rows.push_back('{hll_pkg::OP_UPDATE, 64'h3FF, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_UPDATE, 64'h8000_0000_0000_0000, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_UPDATE, 64'h0000_0000_0000_0401, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_MERGE,  64'd0, 10'd1023, 6'd63, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_MERGE,  64'hFFFF_FFFF_FFFF_FFFF, 10'd5, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_MERGE,  64'd0, 10'd5, 6'd1, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_CLEAR,  64'd0, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b1, '{63'd0, 1'b1}});
      // every register at top rank: harmonic estimate saturates
      rows.push_back('{hll_pkg::OP_MERGE,  64'd0, 10'd0, 6'd63, NREG, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b1, '{EST_MAX, 1'b0}});
      // a lower merge leaves the register alone
      rows.push_back('{hll_pkg::OP_MERGE,  64'd0, 10'd0, 6'd1, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b1, '{EST_MAX, 1'b0}});
      rows.push_back('{hll_pkg::OP_CLEAR,  64'd0, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_FINAL,  64'd0, 10'd0, 6'd0, 1, 1'b0, '0});
      rows.push_back('{hll_pkg::OP_CLEAR,  64'd0, 10'd0, 6'd0, 1, 1'b0, '0});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[r]) begin
         row = rows[r];
         for (int k = 0; k < row.repeat_cnt; k++) begin
            send_item(row.op, row.row_hash, row.reg_index + 10'(k), row.reg_value);
            // literal rows must agree with the model as well
            if (row.has_literal) begin
               got = pending_estimates[pending_estimates.size() - 1];
               if (got != row.literal)
                  report_mismatch($sformatf("row %0d model gives %0d/%0d", r,
                                            got.estimate, got.used_linear));
               pending_estimates[pending_estimates.size() - 1] = row.literal;
            end
         end
      end

      // random traffic with one full fill for the harmonic path
      idle_on = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) begin
            // two finalize transactions back to back while the receiver holds off
            hold_request = 1'b1;
            send_item(hll_pkg::OP_FINAL, {$urandom, $urandom}, 10'($urandom), 6'($urandom));
            send_item(hll_pkg::OP_FINAL, {$urandom, $urandom}, 10'($urandom), 6'($urandom));
         end
         if (n == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
         if (n == 200) begin
            fill_sketch(4);
            send_item(hll_pkg::OP_FINAL, {$urandom, $urandom}, 10'($urandom), 6'($urandom));
         end
         roll = $urandom_range(0, 99);
         if (roll < 5)
            send_item(hll_pkg::OP_FINAL, {$urandom, $urandom}, 10'($urandom), 6'($urandom));
         else if (roll < 6)
            send_item(hll_pkg::OP_CLEAR, {$urandom, $urandom}, 10'($urandom), 6'($urandom));
         else if (roll < 30)
            send_item(hll_pkg::OP_MERGE, {$urandom, $urandom}, 10'($urandom), 6'($urandom));
         else
            send_item(hll_pkg::OP_UPDATE, random_hash(), 10'($urandom), 6'($urandom));
      end
      send_item(hll_pkg::OP_FINAL, 64'd0, 10'd0, 6'd0);
      @(negedge clock);
      req_tvalid = 1'b0;

      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("hyperloglog_distinct_count_sketch_core_tb: clean");
      else
         $display("hyperloglog_distinct_count_sketch_core_tb: errors");
      $finish;
   end

endmodule
